[rtl/cpc_pkg.sv]
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared widths, defaults, register indexes and helpers of the cascade PID.
// ----------------------------------------------------------------------------
package cpc_pkg;

   localparam int DATA_W   = 32;
   localparam int OPND_W   = 33;
   localparam int PROD_W   = 64;
   localparam int CSR_AW   = 3;

   localparam int FRAC_BITS_DEF       = 16;
   localparam int DEADBAND_DEF        = 0;
   localparam int INTEGRAL_LIMIT_DEF  = 6553600;
   localparam int D_ALPHA_DEF         = 32768;
   localparam int OUTER_OUT_LIMIT_DEF = 6553600;

   typedef enum logic [CSR_AW-1:0] {
      REG_OUTER_KP  = 3'd0,
      REG_OUTER_KI  = 3'd1,
      REG_OUTER_KD  = 3'd2,
      REG_INNER_KP  = 3'd3,
      REG_INNER_KI  = 3'd4,
      REG_INNER_KD  = 3'd5,
      REG_DRIVE_MIN = 3'd6,
      REG_DRIVE_MAX = 3'd7
   } csr_index_type;

   // handshake between sequencer and divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = 64'sh0000_0000_7fff_ffff;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         sat32 = 32'sh7fff_ffff;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[DATA_W-1:0];
      end
   endfunction

endpackage

[rtl/cascade_pid_controller_unit.sv]
// ----------------------------------------------------------------------------
// cascade_pid_controller_unit
// Outer and inner PID loops in cascade, fixed point, one shared multiplier.
// ----------------------------------------------------------------------------
// A sample with a positive step_time runs each loop through eleven sequencer
// steps on the one shared multiplier, plus a bit-serial divide for the
// derivative that holds the sequencer until the divider reports done. The
// next request is taken once the result is loaded into the output register.
// A sample with step_time of zero or less changes no loop state and returns
// the held outputs. The block takes one request at a time; a finished result
// waits in the output register while the next request is accepted. Register
// writes are taken at any time but belong between samples.
module cascade_pid_controller_unit import cpc_pkg::*; #(
   parameter int FRAC_BITS       = FRAC_BITS_DEF,
   parameter int DEADBAND        = DEADBAND_DEF,
   parameter int INTEGRAL_LIMIT  = INTEGRAL_LIMIT_DEF,
   parameter int D_ALPHA         = D_ALPHA_DEF,
   parameter int OUTER_OUT_LIMIT = OUTER_OUT_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // target, outer_measure, inner_measure, step_time
   input  logic [127:0]      req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // drive, inner_target
   output logic [63:0]       rsp_tdata,
   // held
   output logic [0:0]        rsp_tuser,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [DATA_W-1:0] csr_data
);

   localparam logic signed [PROD_W-1:0] LIM_POS  = PROD_W'(INTEGRAL_LIMIT);
   localparam logic signed [PROD_W-1:0] LIM_NEG  = -PROD_W'(INTEGRAL_LIMIT);
   localparam logic signed [DATA_W-1:0] OUT_HI   = DATA_W'(OUTER_OUT_LIMIT);
   localparam logic signed [DATA_W-1:0] OUT_LO   = -DATA_W'(OUTER_OUT_LIMIT);
   localparam logic signed [OPND_W-1:0] ALPHA_A  = OPND_W'(D_ALPHA);
   localparam logic signed [OPND_W-1:0] ALPHA_B  = OPND_W'((1 << FRAC_BITS) - D_ALPHA);
   localparam logic signed [OPND_W-1:0] DB_MAG   = OPND_W'(DEADBAND);

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_ERR   = 14'b00000000000010,
      ST_MED   = 14'b00000000000100,
      ST_INTEG = 14'b00000000001000,
      ST_DIVW  = 14'b00000000010000,
      ST_MDA   = 14'b00000000100000,
      ST_MDB   = 14'b00000001000000,
      ST_DFLT  = 14'b00000010000000,
      ST_MKP   = 14'b00000100000000,
      ST_MKI   = 14'b00001000000000,
      ST_MKD   = 14'b00010000000000,
      ST_SUM   = 14'b00100000000000,
      ST_CLAMP = 14'b01000000000000,
      ST_OUTW  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] cfg_ff [8];
   logic signed [DATA_W-1:0] integ_ff [2];
   logic signed [DATA_W-1:0] lerr_ff [2];
   logic signed [DATA_W-1:0] lder_ff [2];
   logic signed [DATA_W-1:0] lout_ff [2];

   logic                     loop_ff;
   logic                     held_ff;
   logic signed [DATA_W-1:0] sp_ff, om_ff, im_ff, dt_ff;
   logic signed [DATA_W-1:0] e_ff, draw_ff, dflt_ff;
   logic signed [PROD_W-1:0] ed_ff, acc_ff;
   logic                     rsp_valid_ff;
   logic [63:0]              rsp_data_ff;
   logic                     rsp_held_ff;

   logic signed [DATA_W-1:0] cur_integ, cur_lerr, cur_lder;
   logic signed [DATA_W-1:0] kp, ki, kd, lo, hi, fb;
   logic signed [OPND_W-1:0] diff, e_mag, op_a, op_b;
   logic signed [DATA_W-1:0] e_val;
   logic signed [PROD_W-1:0] prod, prod_sh, integ_sum, integ_clamp, dsum, backoff;
   logic signed [DATA_W-1:0] out_val;
   logic signed [DATA_W-1:0] div_q;
   logic                     accept, rsp_load;
   div_ctrl_type             div_ctrl;
   div_stat_type             div_stat;

   assign cur_integ = loop_ff ? integ_ff[1] : integ_ff[0];
   assign cur_lerr  = loop_ff ? lerr_ff[1]  : lerr_ff[0];
   assign cur_lder  = loop_ff ? lder_ff[1]  : lder_ff[0];
   assign kp = loop_ff ? cfg_ff[REG_INNER_KP] : cfg_ff[REG_OUTER_KP];
   assign ki = loop_ff ? cfg_ff[REG_INNER_KI] : cfg_ff[REG_OUTER_KI];
   assign kd = loop_ff ? cfg_ff[REG_INNER_KD] : cfg_ff[REG_OUTER_KD];
   assign lo = loop_ff ? cfg_ff[REG_DRIVE_MIN] : OUT_LO;
   assign hi = loop_ff ? cfg_ff[REG_DRIVE_MAX] : OUT_HI;
   assign fb = loop_ff ? im_ff : om_ff;

   // error with saturation and deadband
   assign diff  = OPND_W'(sp_ff) - OPND_W'(fb);
   always_comb begin
      e_val = sat32(PROD_W'(diff));
      e_mag = e_val[DATA_W-1] ? -OPND_W'(e_val) : OPND_W'(e_val);
      if (e_mag < DB_MAG) begin
         e_val = '0;
      end
   end

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_MED: begin op_a = OPND_W'(e_ff); op_b = OPND_W'(dt_ff); end
         ST_MDA: begin op_a = ALPHA_A; op_b = OPND_W'(cur_lder); end
         ST_MDB: begin op_a = ALPHA_B; op_b = OPND_W'(draw_ff); end
         ST_MKP: begin op_a = OPND_W'(kp); op_b = OPND_W'(e_ff); end
         ST_MKI: begin op_a = OPND_W'(ki); op_b = OPND_W'(cur_integ); end
         ST_MKD: begin op_a = OPND_W'(kd); op_b = OPND_W'(dflt_ff); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   cpc_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign div_ctrl.start = (state_ff == ST_INTEG);

   cpc_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .num   (OPND_W'(e_ff) - OPND_W'(cur_lerr)),
      .den   (dt_ff),
      .stat  (div_stat),
      .quo   (div_q)
   );

   assign prod_sh   = prod >>> FRAC_BITS;
   assign integ_sum = PROD_W'(cur_integ) + prod_sh;
   assign integ_clamp = (integ_sum > LIM_POS) ? LIM_POS :
                        ((integ_sum < LIM_NEG) ? LIM_NEG : integ_sum);
   assign dsum    = (acc_ff + prod) >>> FRAC_BITS;
   assign backoff = PROD_W'(cur_integ) - (ed_ff >>> (FRAC_BITS + 1));
   assign out_val = (acc_ff < PROD_W'(lo)) ? lo :
                    ((acc_ff > PROD_W'(hi)) ? hi : acc_ff[DATA_W-1:0]);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_OUTW) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ($signed(req_tdata[127:96]) <= 0) begin
                  state_in = ST_OUTW;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR:   state_in = ST_MED;
         ST_MED:   state_in = ST_INTEG;
         ST_INTEG: state_in = ST_DIVW;
         ST_DIVW: begin
            if (div_stat.done) begin
               state_in = ST_MDA;
            end
         end
         ST_MDA:   state_in = ST_MDB;
         ST_MDB:   state_in = ST_DFLT;
         ST_DFLT:  state_in = ST_MKP;
         ST_MKP:   state_in = ST_MKI;
         ST_MKI:   state_in = ST_MKD;
         ST_MKD:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = loop_ff ? ST_OUTW : ST_ERR;
         ST_OUTW: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         loop_ff      <= 1'b0;
         held_ff      <= 1'b0;
         cfg_ff[REG_OUTER_KP]  <= 32'sd65536;
         cfg_ff[REG_OUTER_KI]  <= '0;
         cfg_ff[REG_OUTER_KD]  <= '0;
         cfg_ff[REG_INNER_KP]  <= 32'sd65536;
         cfg_ff[REG_INNER_KI]  <= '0;
         cfg_ff[REG_INNER_KD]  <= '0;
         cfg_ff[REG_DRIVE_MIN] <= -32'sd6553600;
         cfg_ff[REG_DRIVE_MAX] <= 32'sd6553600;
         for (int i = 0; i < 2; i++) begin
            integ_ff[i] <= '0;
            lerr_ff[i]  <= '0;
            lder_ff[i]  <= '0;
            lout_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            cfg_ff[csr_index] <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            loop_ff <= 1'b0;
            held_ff <= ($signed(req_tdata[127:96]) <= 0);
         end
         case (state_ff)
            ST_INTEG: integ_ff[loop_ff] <= integ_clamp[DATA_W-1:0];
            ST_CLAMP: begin
               if (out_val >= hi || out_val <= lo) begin
                  integ_ff[loop_ff] <= sat32(backoff);
               end
               lerr_ff[loop_ff] <= e_ff;
               lder_ff[loop_ff] <= dflt_ff;
               lout_ff[loop_ff] <= out_val;
               loop_ff          <= 1'b1;
            end
            default: ;
         endcase
      end
      // datapath registers
      if (accept) begin
         sp_ff <= req_tdata[31:0];
         om_ff <= req_tdata[63:32];
         im_ff <= req_tdata[95:64];
         dt_ff <= req_tdata[127:96];
      end
      case (state_ff)
         ST_ERR:   e_ff <= e_val;
         ST_INTEG: ed_ff <= prod;
         ST_DIVW:  draw_ff <= div_q;
         ST_MDB:   acc_ff <= prod;
         ST_DFLT:  dflt_ff <= sat32(dsum);
         ST_MKI:   acc_ff <= prod_sh;
         ST_MKD:   acc_ff <= acc_ff + prod_sh;
         ST_SUM:   acc_ff <= acc_ff + prod_sh;
         ST_CLAMP: sp_ff <= out_val;
         default: ;
      endcase
      if (rsp_load) begin
         rsp_data_ff <= {lout_ff[0], lout_ff[1]};
         rsp_held_ff <= held_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_held_ff;

endmodule

[rtl/cpc_mul.sv]
// ----------------------------------------------------------------------------
// cpc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cpc_mul import cpc_pkg::*; (
   input  logic                     clock,
   input  logic signed [OPND_W-1:0] op_a,
   input  logic signed [OPND_W-1:0] op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [2*OPND_W-1:0] full_in;
   logic signed [PROD_W-1:0]   prod_ff;

   assign full_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= full_in[PROD_W-1:0];
   end

   assign prod = prod_ff;

endmodule

[rtl/cpc_div.sv]
// ----------------------------------------------------------------------------
// cpc_div
// Bit-serial divider: sat32(trunc(num * 2^FRAC_BITS / den)), den positive.
// ----------------------------------------------------------------------------
module cpc_div import cpc_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  div_ctrl_type             ctrl,
   input  logic signed [OPND_W-1:0] num,
   input  logic signed [DATA_W-1:0] den,
   output div_stat_type             stat,
   output logic signed [DATA_W-1:0] quo
);

   localparam int DW  = OPND_W + FRAC_BITS;
   localparam int CW  = $clog2(DW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     dvd_ff, dvd_in;
   logic [OPND_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [OPND_W-1:0] num_mag;
   logic [OPND_W-1:0] shifted;
   logic [OPND_W:0]   trial;
   logic signed [PROD_W-1:0] qval;

   assign num_mag = num[OPND_W-1] ? OPND_W'(-num) : OPND_W'(num);
   assign shifted = {rem_ff[OPND_W-2:0], dvd_ff[DW-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff[DATA_W-2:0]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         neg_in  = num[OPND_W-1];
         cnt_in  = CW'(DW);
         dvd_in  = {num_mag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // quotient bits shift in where dividend bits leave
         if (!trial[OPND_W]) begin
            rem_in = trial[OPND_W-1:0];
            dvd_in = {dvd_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign qval      = neg_ff ? -$signed(PROD_W'(dvd_ff)) : $signed(PROD_W'(dvd_ff));
   assign quo       = sat32(qval);
   assign stat.done = done_ff;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cascade PID unit. A predictor tracks both loops
// in 64-bit integer arithmetic. Each accepted request queues one expected
// response, and each response is checked field by field against that queue.
// Gains and drive limits are stepped through several settings, the extremes
// among them, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   import cpc_pkg::*;

   typedef struct {
      logic [31:0] drive;
      logic [31:0] inner_target;
      logic        held;
   } pid_response_type;

   class pid_scoreboard;
      localparam int F = FRAC_BITS_DEF;
      localparam longint ONE = longint'(1) << F;

      longint gain[8];
      longint o_integ, o_err, o_deriv, o_out;
      longint i_integ, i_err, i_deriv, drive_now;
      pid_response_type pending_q[$];
      int errors;
      int checked;
      int held_seen;

      function new();
         gain[REG_OUTER_KP]  = 65536;
         gain[REG_OUTER_KI]  = 0;
         gain[REG_OUTER_KD]  = 0;
         gain[REG_INNER_KP]  = 65536;
         gain[REG_INNER_KI]  = 0;
         gain[REG_INNER_KD]  = 0;
         gain[REG_DRIVE_MIN] = -6553600;
         gain[REG_DRIVE_MAX] = 6553600;
         o_integ = 0; o_err = 0; o_deriv = 0; o_out = 0;
         i_integ = 0; i_err = 0; i_deriv = 0; drive_now = 0;
         errors = 0; checked = 0; held_seen = 0;
      endfunction

      function void write_gain(csr_index_type idx, logic [31:0] v);
         gain[idx] = longint'($signed(v));
      endfunction

      function longint clip32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint pid_step(longint sp, longint fb, longint dt, longint kp, longint ki,
                                longint kd, longint lo, longint hi, inout longint integ,
                                inout longint lerr, inout longint lder);
         longint e, mag, ed, draw, dflt, u, res;
         e = clip32(sp - fb);
         mag = (e < 0) ? -e : e;
         if (mag < DEADBAND_DEF) e = 0;
         ed = e * dt;
         integ = integ + (ed >>> F);
         if (integ > INTEGRAL_LIMIT_DEF) integ = INTEGRAL_LIMIT_DEF;
         if (integ < -INTEGRAL_LIMIT_DEF) integ = -INTEGRAL_LIMIT_DEF;
         draw = clip32(((e - lerr) * ONE) / dt);
         dflt = clip32((D_ALPHA_DEF * lder + (ONE - D_ALPHA_DEF) * draw) >>> F);
         u = ((kp * e) >>> F) + ((ki * integ) >>> F) + ((kd * dflt) >>> F);
         res = (u < lo) ? lo : ((u > hi) ? hi : u);
         // anti-windup back-off, not re-clamped to the integral limit
         if (res >= hi || res <= lo) integ = clip32(integ - (ed >>> (F + 1)));
         lerr = e;
         lder = dflt;
         return res;
      endfunction

      function void note_request(logic [127:0] d);
         longint tgt, om, im, dt;
         pid_response_type r;
         tgt = longint'($signed(d[31:0]));
         om  = longint'($signed(d[63:32]));
         im  = longint'($signed(d[95:64]));
         dt  = longint'($signed(d[127:96]));
         r.held = (dt <= 0);
         if (!r.held) begin
            o_out = pid_step(tgt, om, dt, gain[REG_OUTER_KP], gain[REG_OUTER_KI],
                             gain[REG_OUTER_KD], -OUTER_OUT_LIMIT_DEF, OUTER_OUT_LIMIT_DEF,
                             o_integ, o_err, o_deriv);
            drive_now = pid_step(o_out, im, dt, gain[REG_INNER_KP], gain[REG_INNER_KI],
                                 gain[REG_INNER_KD], gain[REG_DRIVE_MIN],
                                 gain[REG_DRIVE_MAX], i_integ, i_err, i_deriv);
         end else begin
            held_seen++;
         end
         r.drive = drive_now[31:0];
         r.inner_target = o_out[31:0];
         pending_q.push_back(r);
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic [31:0] drive, logic [31:0] itgt, logic held);
         pid_response_type x;
         if (pending_q.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         x = pending_q.pop_front();
         checked++;
         if (drive !== x.drive)
            report($sformatf("drive %h, want %h", drive, x.drive));
         if (itgt !== x.inner_target)
            report($sformatf("inner_target %h, want %h", itgt, x.inner_target));
         if (held !== x.held)
            report($sformatf("held %b, want %b", held, x.held));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [127:0]      req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [63:0]       rsp_tdata;
   logic [0:0]        rsp_tuser;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   pid_scoreboard sb = new();

   cascade_pid_controller_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_gain(csr_index_type'(csr_index), csr_data);
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata[31:0], rsp_tdata[63:32],
                                                         rsp_tuser[0]);
      end
   end

   task write_csr(csr_index_type idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
   endtask

   task program_gains(logic [31:0] okp, logic [31:0] oki, logic [31:0] okd,
                      logic [31:0] ikp, logic [31:0] iki, logic [31:0] ikd,
                      logic [31:0] dmin, logic [31:0] dmax);
      write_csr(REG_OUTER_KP, okp);
      write_csr(REG_OUTER_KI, oki);
      write_csr(REG_OUTER_KD, okd);
      write_csr(REG_INNER_KP, ikp);
      write_csr(REG_INNER_KI, iki);
      write_csr(REG_INNER_KD, ikd);
      write_csr(REG_DRIVE_MIN, dmin);
      write_csr(REG_DRIVE_MAX, dmax);
      csr_valid <= 1'b0;
   endtask

   task send_sample(logic [31:0] tgt, logic [31:0] om, logic [31:0] im, logic [31:0] dt);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {dt, im, om, tgt};
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off until every outstanding response is back
   task drain();
      req_tvalid <= 1'b0;
      // let the monitor note the request taken at this edge
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function logic [31:0] pick_value(bit wide);
      if (wide) return $urandom;
      return $urandom_range(26214400) - 13107200;
   endfunction

   function logic [31:0] pick_gain();
      logic [31:0] g;
      g = $urandom_range(32'h30000);
      return $urandom_range(1) ? -g : g;
   endfunction

   task random_sample();
      int kind;
      logic [31:0] dt;
      kind = $urandom_range(99);
      if (kind < 70) dt = $urandom_range(131072, 1);
      else if (kind < 80) dt = $urandom_range(1) ? 32'd0 : (32'h8000_0000 | $urandom);
      else dt = $urandom;
      send_sample(pick_value(kind >= 80), pick_value(kind >= 80), pick_value(kind >= 80), dt);
   endtask

   localparam int PHASES = 6;
   localparam int PER_PHASE = 322;

   initial begin
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset gains: extremes, held samples, tiny and huge step times
      send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'd65536);
      send_sample(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
      send_sample(32'h0, 32'h0, 32'h8000_0000, 32'h7fff_ffff);
      send_sample(32'h0010_0000, 32'h0, 32'h0, 32'd0);
      send_sample(32'h0010_0000, 32'h0, 32'h0, 32'h8000_0000);
      send_sample(32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff);
      send_sample(32'h0002_0000, 32'h0001_0000, 32'hffff_0000, 32'd655);
      send_sample(32'h0, 32'h0, 32'h0, 32'd65536);
      drain();
      program_gains(32'h0002_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_8000,
                    32'h0000_2000, 32'h0000_1000, 32'hff9c_0000, 32'h0064_0000);
      send_sample(32'h0050_0000, 32'h0, 32'h0, 32'd65536);
      send_sample(32'h0050_0000, 32'h0010_0000, 32'h0001_0000, 32'd1);
      send_sample(32'h0050_0000, 32'h0020_0000, 32'h0002_0000, 32'h7fff_ffff);
      send_sample(32'h0, 32'h0, 32'h0, 32'd0);
      send_sample(32'hffb0_0000, 32'h0, 32'h0, 32'd6553);
      drain();
      // extreme gains and full-range drive limits
      program_gains(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_sample(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_sample(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd1);
      send_sample(32'h1234_5678, 32'h8765_4321, 32'h0, 32'd65536);
      drain();
      // inverted drive limits: the low bound is tested first
      program_gains(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
                    32'h0064_0000, 32'hff9c_0000);
      send_sample(32'h0010_0000, 32'h0, 32'h0, 32'd65536);
      send_sample(32'hff00_0000, 32'h0, 32'h0, 32'd65536);
      send_sample(32'h0, 32'h0, 32'h0, 32'd65536);
      drain();

      k = 0;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_gains(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
                             32'hff9c_0000, 32'h0064_0000);
            1: program_gains(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
            2: program_gains(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                             32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
            3: program_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                             pick_gain(), 32'h0032_0000, 32'hffce_0000);
            default: program_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                   pick_gain(), pick_gain(),
                                   -$urandom_range(32'h0100_0000),
                                   $urandom_range(32'h0100_0000));
         endcase
         for (int i = 0; i < PER_PHASE; i++) begin
            if (k < PHASES * PER_PHASE / 3) begin
               tx_idle_pct = 34; rx_idle_pct = 76;
            end else if (k < 2 * PHASES * PER_PHASE / 3) begin
               tx_idle_pct = 76; rx_idle_pct = 34;
            end else begin
               tx_idle_pct = 0; rx_idle_pct = 0;
            end
            if (i == PER_PHASE / 2) drain();
            random_sample();
            k++;
         end
         drain();
      end

      rx_idle_pct = 0;
      drain();
      repeat (200) @(posedge clock);
      $display("checked %0d responses (%0d held) across %0d gain settings",
               sb.checked, sb.held_seen, PHASES + 4);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[cascade_pid_controller_unit] OK");
      end else begin
         $display("[cascade_pid_controller_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("timeout");
      $display("[cascade_pid_controller_unit] ERROR");
      $finish;
   end

endmodule
